### rtl/core/dlvr_pkg.sv
`default_nettype none
package dlvr_pkg;
   localparam int Depth = 16;
   localparam int SlotW = $clog2(Depth);
   localparam int FillW = $clog2(Depth + 1);
   localparam int BytesW = 24;
   localparam int TimeW = 32;
   localparam int MinW = 31;
   localparam int RateW = 48;
   localparam int TotalW = BytesW + SlotW + 1;
   localparam int DelayW = 33;
   localparam int NumW = TotalW + 21;
   localparam int QueueDepth = 2;
   localparam logic [19:0] UsecPerSec = 20'd1000000;

   typedef struct packed {
      logic [BytesW-1:0] bytes_sent;
      logic [TimeW-1:0]  depart_time;
      logic [TimeW-1:0]  arrive_time;
   } sample_type;

   typedef struct packed {
      sample_type     smp;
      logic [SlotW-1:0] slot;
      logic [FillW-1:0] fill;
   } job_type;

   // delay = signed(later - earlier) - min, floored at one
   function automatic logic [DelayW-1:0] delay_of(input logic [TimeW-1:0] later,
                                                   input logic [TimeW-1:0] earlier,
                                                   input logic [MinW-1:0] min_rt);
      logic [TimeW-1:0] diff;
      logic signed [TimeW+1:0] d;
      diff = later - earlier;
      d = $signed({{2{diff[TimeW-1]}}, diff}) - $signed({3'b000, min_rt});
      if (d < 34'sd1) delay_of = DelayW'(1);
      else delay_of = d[DelayW-1:0];
   endfunction
endpackage
`default_nettype wire

### rtl/core/delivery_rate_bandwidth_estimator_core.sv
// Delivery-rate bandwidth estimator.
// req_ channel: one acknowledged transfer per request (bytes, depart and
//   arrive timestamps in microseconds). rsp_ channel: one rate_estimate
//   per request, bytes per second, in request order.
// csr_ channel: writes min_round_trip; write only while idle.
// A front stage tags each request with its ring slot and fill count and
// queues it (two entries); the back stage stores the sample and walks all
// valid samples plus the congested total through one shared restoring
// divider that produces one quotient bit per cycle.
// Each sample is read, multiplied, started and divided in turn; the
//   total then takes the multiply, start and division steps once more.
//   The back stage takes a new request only after the last estimate is
//   registered for output; the queue holds the requests in between.
// Reset (synchronous, active high) empties the ring and the queue and
//   clears min_round_trip. A stalled rsp_ready holds the result register;
//   the queue keeps taking requests until full.
`default_nettype none
module delivery_rate_bandwidth_estimator_core import dlvr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic [BytesW-1:0] req_bytes_sent,
   input  wire logic [TimeW-1:0]  req_depart_time,
   input  wire logic [TimeW-1:0]  req_arrive_time,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic [RateW-1:0] rsp_rate_estimate,
   input  wire logic csr_valid,
   output logic      csr_ready,
   input  wire logic [MinW-1:0] csr_min_round_trip
);
   logic [MinW-1:0] min_rt_ff;
   logic job_valid, job_ready;
   job_type job;

   // accept register writes at any time
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) min_rt_ff <= '0;
      else if (csr_valid) min_rt_ff <= csr_min_round_trip;
   end

   dlvr_front u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_bytes_sent(req_bytes_sent), .req_depart_time(req_depart_time),
      .req_arrive_time(req_arrive_time),
      .job_valid(job_valid), .job_ready(job_ready), .job(job)
   );

   dlvr_back u_back (
      .clock(clock), .reset(reset),
      .job_valid(job_valid), .job_ready(job_ready), .job(job),
      .min_rt(min_rt_ff),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_rate_estimate(rsp_rate_estimate)
   );
endmodule
`default_nettype wire

### rtl/core/dlvr_front.sv
`default_nettype none
module dlvr_front import dlvr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_valid,
   output logic      req_ready,
   input  wire logic [BytesW-1:0] req_bytes_sent,
   input  wire logic [TimeW-1:0]  req_depart_time,
   input  wire logic [TimeW-1:0]  req_arrive_time,
   output logic      job_valid,
   input  wire logic job_ready,
   output job_type   job
);
   // tag each request with its ring slot and fill count
   logic [SlotW-1:0] slot_ff, slot_in;
   logic [FillW-1:0] fill_ff, fill_in;
   job_type q_ff [QueueDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic push, pop;

   assign req_ready = (cnt_ff != 2'(QueueDepth));
   assign push = req_valid && req_ready;
   assign pop = job_valid && job_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job = q_ff[rd_ff];

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      wr_in = wr_ff;
      if (push) begin
         slot_in = (slot_ff == SlotW'(Depth - 1)) ? '0 : slot_ff + 1'b1;
         if (fill_ff != FillW'(Depth)) fill_in = fill_ff + 1'b1;
         wr_in = ~wr_ff;
      end
      if (pop) rd_in = ~rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push) begin
         q_ff[wr_ff].smp.bytes_sent <= req_bytes_sent;
         q_ff[wr_ff].smp.depart_time <= req_depart_time;
         q_ff[wr_ff].smp.arrive_time <= req_arrive_time;
         q_ff[wr_ff].slot <= slot_ff;
         q_ff[wr_ff].fill <= fill_in;
      end
   end
endmodule
`default_nettype wire

### rtl/core/dlvr_div.sv
`default_nettype none
module dlvr_div import dlvr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic [NumW-1:0] num,
   input  wire logic [DelayW:0] den,
   output logic      done,
   output logic [NumW-1:0] quo
);
   // restoring divider, one quotient bit per cycle
   logic [NumW-1:0] q_ff, q_in;
   logic [DelayW+1:0] r_ff, r_in;
   logic [DelayW:0] d_ff;
   logic [6:0] n_ff, n_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [DelayW+1:0] sh;

   assign done = done_ff;
   assign quo = q_ff;
   assign sh = {r_ff[DelayW:0], q_ff[NumW-1]};

   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      n_in = n_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = num;
         r_in = '0;
         n_in = 7'(NumW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (sh >= {1'b0, d_ff}) begin
            r_in = sh - {1'b0, d_ff};
            q_in = {q_ff[NumW-2:0], 1'b1};
         end else begin
            r_in = sh;
            q_in = {q_ff[NumW-2:0], 1'b0};
         end
         n_in = n_ff - 1'b1;
         if (n_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         n_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         n_ff <= n_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= den;
   end
endmodule
`default_nettype wire

### rtl/core/dlvr_back.sv
`default_nettype none
module dlvr_back import dlvr_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic job_valid,
   output logic      job_ready,
   input  wire job_type job,
   input  wire logic [MinW-1:0] min_rt,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic [RateW-1:0] rsp_rate_estimate
);
   localparam logic [2:0] StIdle = 3'd0, StRead = 3'd1, StMul = 3'd2,
                          StDiv = 3'd3, StWait = 3'd4, StOut = 3'd5;

   logic [BytesW-1:0] mb_ff [Depth];
   logic [TimeW-1:0]  md_ff [Depth];
   logic [TimeW-1:0]  ma_ff [Depth];

   logic [2:0] st_ff, st_in;
   logic [SlotW-1:0] oldest_ff;
   logic [FillW-1:0] fill_ff, idx_ff, idx_in;
   logic last_ff, last_in;
   logic [BytesW-1:0] rb_ff;
   logic [TimeW-1:0] rd_ff, ra_ff, newest_arr_ff, oldest_dep_ff;
   logic [TotalW-1:0] total_ff, total_in;
   logic [NumW-1:0] num_ff;
   logic [NumW-1:0] div_num;
   logic [DelayW-1:0] dly_ff;
   logic [RateW-1:0] best_ff, best_in;
   logic out_ff, out_in;
   logic [RateW-1:0] out_rate_ff;
   logic div_start, div_done;
   logic [NumW-1:0] quo;
   logic [SlotW-1:0] rslot;
   logic [TotalW-1:0] mul_src;
   logic [NumW:0] q_ext;

   assign job_ready = (st_ff == StIdle);
   assign rsp_valid = out_ff;
   assign rsp_rate_estimate = out_rate_ff;
   assign div_start = (st_ff == StDiv);
   assign rslot = SlotW'(oldest_ff + SlotW'(idx_ff));
   assign mul_src = last_ff ? total_ff : TotalW'(rb_ff);
   // add the delay for half-up rounding
   assign div_num = num_ff + NumW'(dly_ff);

   dlvr_div u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den({dly_ff, 1'b0}), .done(div_done), .quo(quo)
   );

   always_comb begin
      st_in = st_ff;
      idx_in = idx_ff;
      last_in = last_ff;
      total_in = total_ff;
      best_in = best_ff;
      out_in = out_ff;
      q_ext = {1'b0, quo};
      if (out_ff && rsp_ready) out_in = 1'b0;
      case (st_ff)
         StIdle: begin
            if (job_valid) begin
               st_in = StRead;
               idx_in = '0;
               last_in = 1'b0;
               total_in = '0;
               best_in = '0;
            end
         end
         StRead: st_in = StMul;
         StMul: begin
            st_in = StDiv;
            if (!last_ff) total_in = total_ff + TotalW'(rb_ff);
         end
         StDiv: st_in = StWait;
         StWait: begin
            if (div_done) begin
               if (quo > NumW'({RateW{1'b1}})) q_ext = {1'b0, NumW'({RateW{1'b1}})};
               if (q_ext[RateW-1:0] > best_ff) best_in = q_ext[RateW-1:0];
               if (last_ff) begin
                  st_in = StOut;
               end else if (idx_ff + 1'b1 == fill_ff) begin
                  last_in = 1'b1;
                  st_in = StMul;
               end else begin
                  idx_in = idx_ff + 1'b1;
                  st_in = StRead;
               end
            end
         end
         StOut: begin
            if (!out_ff || rsp_ready) begin
               out_in = 1'b1;
               st_in = StIdle;
            end
         end
         default: st_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= StIdle;
         out_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         out_ff <= out_in;
      end
      idx_ff <= idx_in;
      last_ff <= last_in;
      best_ff <= best_in;
      total_ff <= total_in;
      if (st_ff == StIdle && job_valid) begin
         mb_ff[job.slot] <= job.smp.bytes_sent;
         md_ff[job.slot] <= job.smp.depart_time;
         ma_ff[job.slot] <= job.smp.arrive_time;
         fill_ff <= job.fill;
         oldest_ff <= SlotW'(job.slot + 1'b1 - SlotW'(job.fill));
         newest_arr_ff <= job.smp.arrive_time;
      end
      if (st_ff == StRead) begin
         rb_ff <= mb_ff[rslot];
         rd_ff <= md_ff[rslot];
         ra_ff <= ma_ff[rslot];
         if (idx_ff == '0) oldest_dep_ff <= md_ff[rslot];
      end
      if (st_ff == StMul) begin
         num_ff <= mul_src * UsecPerSec * 2'd2;
         if (last_ff) dly_ff <= delay_of(newest_arr_ff, oldest_dep_ff, min_rt);
         else dly_ff <= delay_of(ra_ff, rd_ff, min_rt);
      end
      if (st_ff == StOut && (!out_ff || rsp_ready)) out_rate_ff <= best_ff;
   end
endmodule
`default_nettype wire

### rtl/core/dlvr_checker.sv
`default_nettype none
module dlvr_checker import dlvr_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic [RateW-1:0] rsp_rate_estimate,
   input wire logic csr_ready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rate_estimate))
      else $error("rsp dropped while stalled");
   a_rst: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid after reset");
   a_csr: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("csr not ready");
endmodule
bind delivery_rate_bandwidth_estimator_core dlvr_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_rate_estimate(rsp_rate_estimate), .csr_ready(csr_ready)
);
`default_nettype wire
